@@ hdl/rss_pkg.sv @@
// ----------------------------------------------------------------------------
// rss_pkg
// shared widths, request kinds and status codes of the random sampling set
// ----------------------------------------------------------------------------
package rss_pkg;

	localparam int VAL_W     = 32;  // member value width
	localparam int RW_W      = 31;  // random word width
	localparam int KIND_W    = 2;   // request kind / status width
	localparam int MCOUNT_W  = 7;   // member count field width
	localparam int S_TDATA_W = 64;  // item_value, random_word, pad
	localparam int M_TDATA_W = 40;  // picked_value, member_count, pad

	// request kinds
	localparam logic [KIND_W-1:0] REQ_INSERT = 2'd0;
	localparam logic [KIND_W-1:0] REQ_REMOVE = 2'd1;
	localparam logic [KIND_W-1:0] REQ_PICK   = 2'd2;

	// status codes
	localparam logic [KIND_W-1:0] STAT_DONE  = 2'd0;
	localparam logic [KIND_W-1:0] STAT_NOP   = 2'd1;  // already present or absent
	localparam logic [KIND_W-1:0] STAT_FULL  = 2'd2;
	localparam logic [KIND_W-1:0] STAT_EMPTY = 2'd3;

	typedef logic [VAL_W-1:0] value_t;

endpackage

@@ hdl/random_sampling_set.sv @@
// ----------------------------------------------------------------------------
// random_sampling_set
// bounded set of distinct 32-bit values with insert, remove and random pick
// ----------------------------------------------------------------------------
// Members sit densely in one memory at indexes 0 .. count-1. The block takes
// one request beat at a time and answers each with one result beat. Insert
// and remove first scan the live entries through the single memory read
// port, one entry per cycle; a remove that hits then copies the last entry
// into the freed slot. A random pick runs the bit-serial remainder unit (one
// bit of the random word a cycle) and then reads the chosen entry. An empty
// pick and an unused request kind go straight to loading the result. The
// next request beat is taken once the result is loaded into the output
// register, so a result may wait there while the next request works.
// ----------------------------------------------------------------------------
module random_sampling_set
	import rss_pkg::*;
#(
	parameter int CAPACITY = 64
) (
	input  logic                 clk,
	input  logic                 arst_n,
	// request side
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [S_TDATA_W-1:0] s_tdata,   // [31:0] item_value, [62:32] random_word, [63] zero
	input  logic [KIND_W-1:0]    s_tuser,   // [1:0] req_type
	// result side
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [M_TDATA_W-1:0] m_tdata,   // [31:0] picked_value, [38:32] member_count, [39] zero
	output logic [KIND_W-1:0]    m_tuser    // [1:0] status
);

	localparam int AW = $clog2(CAPACITY);      // memory address width
	localparam int CW = $clog2(CAPACITY + 1);  // count width, holds CAPACITY itself

	typedef enum logic [2:0] {
		IDLE,      // waiting for a request beat
		SEARCH,    // scanning live entries for the value
		RM_RD,     // read the last entry
		RM_WR,     // move it into the freed slot
		DIV_WAIT,  // remainder unit running
		PK_RD,     // read the picked entry
		PK_CAP,    // capture the picked value
		RESP       // load the result register
	} state_t;

	state_t             state_q;
	logic [CW-1:0]      count_q;     // live member count
	logic [KIND_W-1:0]  req_q;
	value_t             value_q;
	logic [KIND_W-1:0]  status_q;
	value_t             picked_q;
	logic [CW-1:0]      rd_idx_q;    // next index to read in the scan
	logic [CW-1:0]      cmp_idx_q;   // index whose data is on the read port
	logic               cmp_vld_q;
	logic [AW-1:0]      pos_q;       // slot of the value being removed

	logic               m_tvalid_q;
	logic [M_TDATA_W-1:0] m_tdata_q;
	logic [KIND_W-1:0]  m_tuser_q;

	// memory and remainder unit hookup
	logic               mem_we;
	logic [AW-1:0]      mem_waddr;
	value_t             mem_wdata;
	logic [AW-1:0]      mem_raddr;
	value_t             mem_rdata;
	logic               div_start;
	logic               div_done;
	logic [CW-1:0]      div_rem;

	logic               accept;
	logic               hit;
	logic               scan_end;
	logic               full;
	logic [CW-1:0]      last_idx;
	logic [CW+MCOUNT_W-1:0] count_ext;

	assign s_tready  = (state_q == IDLE);
	assign accept    = s_tvalid && s_tready;
	assign hit       = cmp_vld_q && (mem_rdata == value_q);
	// scan finished with no hit: nothing pending and every live index read
	assign scan_end  = !cmp_vld_q && (rd_idx_q >= count_q);
	assign full      = (count_q >= CW'(CAPACITY));
	assign last_idx  = count_q - 1'b1;
	assign count_ext = {{MCOUNT_W{1'b0}}, count_q};

	assign div_start = accept && (s_tuser == REQ_PICK) && (count_q != '0);

	// read address follows the sequencer step
	always_comb begin
		case (state_q)
			SEARCH:  mem_raddr = rd_idx_q[AW-1:0];
			RM_RD:   mem_raddr = last_idx[AW-1:0];
			PK_RD:   mem_raddr = div_rem[AW-1:0];
			default: mem_raddr = '0;
		endcase
	end

	// insert writes at the tail, remove writes the moved entry into the hole
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = '0;
		mem_wdata = value_q;
		case (state_q)
			SEARCH: begin
				if (!hit && scan_end && (req_q == REQ_INSERT) && !full) begin
					mem_we    = 1'b1;
					mem_waddr = count_q[AW-1:0];
				end
			end
			RM_WR: begin
				mem_we    = 1'b1;
				mem_waddr = pos_q;
				mem_wdata = mem_rdata;
			end
			default: ;
		endcase
	end

	// sequencer with its registered outputs
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= IDLE;
			count_q    <= '0;
			cmp_vld_q  <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			// result beat taken; a reload in RESP keeps it valid instead
			if (m_tvalid_q && m_tready && (state_q != RESP)) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				IDLE: begin
					if (accept) begin
						rd_idx_q  <= '0;
						cmp_vld_q <= 1'b0;
						picked_q  <= '0;
						case (s_tuser)
							REQ_INSERT, REQ_REMOVE: begin
								status_q <= STAT_DONE;
								state_q  <= SEARCH;
							end
							REQ_PICK: begin
								if (count_q == '0) begin
									status_q <= STAT_EMPTY;
									state_q  <= RESP;
								end else begin
									status_q <= STAT_DONE;
									state_q  <= DIV_WAIT;
								end
							end
							default: begin  // unused kind, no change
								status_q <= STAT_DONE;
								state_q  <= RESP;
							end
						endcase
					end
				end
				SEARCH: begin
					if (hit) begin
						cmp_vld_q <= 1'b0;
						pos_q     <= cmp_idx_q[AW-1:0];
						if (req_q == REQ_INSERT) begin
							status_q <= STAT_NOP;
							state_q  <= RESP;
						end else begin
							state_q <= RM_RD;
						end
					end else if (rd_idx_q < count_q) begin
						cmp_idx_q <= rd_idx_q;
						cmp_vld_q <= 1'b1;
						rd_idx_q  <= rd_idx_q + 1'b1;
					end else if (cmp_vld_q) begin
						cmp_vld_q <= 1'b0;  // last read still in flight
					end else begin
						state_q <= RESP;
						if (req_q == REQ_INSERT) begin
							if (full) begin
								status_q <= STAT_FULL;
							end else begin
								count_q <= count_q + 1'b1;
							end
						end else begin
							status_q <= STAT_NOP;
						end
					end
				end
				RM_RD: state_q <= RM_WR;
				RM_WR: begin
					count_q <= last_idx;
					state_q <= RESP;
				end
				DIV_WAIT: begin
					if (div_done) begin
						state_q <= PK_RD;
					end
				end
				PK_RD: state_q <= PK_CAP;
				PK_CAP: begin
					picked_q <= mem_rdata;
					state_q  <= RESP;
				end
				RESP: begin
					if (!m_tvalid_q || m_tready) begin
						m_tvalid_q <= 1'b1;
						m_tuser_q  <= status_q;
						m_tdata_q  <= {1'b0, count_ext[MCOUNT_W-1:0], picked_q};
						state_q    <= IDLE;
					end
				end
				default: state_q <= IDLE;
			endcase
		end
	end

	// request payload capture
	always_ff @(posedge clk) begin
		if (accept) begin
			req_q   <= s_tuser;
			value_q <= s_tdata[VAL_W-1:0];
		end
	end

	rss_store #(
		.DEPTH (CAPACITY),
		.AW    (AW)
	) u_store (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	rss_divider #(
		.CW (CW)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (s_tdata[VAL_W+RW_W-1:VAL_W]),
		.divisor  (count_q),
		.done     (div_done),
		.rem      (div_rem)
	);

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

endmodule

@@ hdl/rss_store.sv @@
// ----------------------------------------------------------------------------
// rss_store
// member storage: one write port, one read port with registered read data
// ----------------------------------------------------------------------------
module rss_store
	import rss_pkg::*;
#(
	parameter int DEPTH = 64,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  value_t        wdata,
	input  logic [AW-1:0] raddr,
	output value_t        rdata
);

	value_t mem_q [DEPTH];
	value_t rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

@@ hdl/rss_divider.sv @@
// ----------------------------------------------------------------------------
// rss_divider
// bit-serial restoring remainder: random word mod live count, one bit a cycle
// ----------------------------------------------------------------------------
module rss_divider
	import rss_pkg::*;
#(
	parameter int CW = 7
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  logic [RW_W-1:0] dividend,
	input  logic [CW-1:0]   divisor,
	output logic            done,
	output logic [CW-1:0]   rem
);

	localparam int SW = $clog2(RW_W);

	logic            busy_q;
	logic            done_q;
	logic [SW-1:0]   step_q;
	logic [RW_W-1:0] quo_q;
	logic [CW-1:0]   rem_q;
	logic [CW-1:0]   div_q;

	logic [CW:0] shifted;
	logic [CW:0] diff;
	logic [CW-1:0] rem_nxt;

	always_comb begin
		shifted = {rem_q, quo_q[RW_W-1]};
		diff    = shifted - {1'b0, div_q};
		rem_nxt = (shifted >= {1'b0, div_q}) ? diff[CW-1:0] : shifted[CW-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			// pulse after the last bit has been folded in
			done_q <= !start && busy_q && (step_q == SW'(RW_W - 1));
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + 1'b1;
				if (step_q == SW'(RW_W - 1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			div_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[RW_W-2:0], 1'b0};
			rem_q <= rem_nxt;
		end
	end

	assign done = done_q;
	assign rem  = rem_q;

endmodule

@@ hdl/rss_checker.sv @@
// ----------------------------------------------------------------------------
// rss_checker
// port-level checks of the random sampling set, bound to the top level
// ----------------------------------------------------------------------------
module rss_checker
	import rss_pkg::*;
#(
	parameter int CAPACITY = 64
) (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 s_tvalid,
	input logic                 s_tready,
	input logic                 m_tvalid,
	input logic                 m_tready,
	input logic [M_TDATA_W-1:0] m_tdata,
	input logic [KIND_W-1:0]    m_tuser
);

	localparam logic [MCOUNT_W-1:0] CAP_MCOUNT = MCOUNT_W'(CAPACITY);

	// a stalled result beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result beat changed while stalled");

	// one request at a time: busy right after a request beat
	a_busy_after_req: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("request taken while previous one in progress");

	// an empty pick reports zero value and zero members
	a_empty_pick: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser == STAT_EMPTY) |->
		(m_tdata[VAL_W-1:0] == '0) && (m_tdata[VAL_W+MCOUNT_W-1:VAL_W] == '0))
		else $error("empty pick with nonzero value or count");

	// a refused insert only happens at capacity
	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser == STAT_FULL) |->
		(m_tdata[VAL_W+MCOUNT_W-1:VAL_W] == CAP_MCOUNT) && (m_tdata[VAL_W-1:0] == '0))
		else $error("set full reported below capacity");

endmodule

bind random_sampling_set rss_checker #(.CAPACITY(CAPACITY)) u_rss_checker (.*);

@@ tb/sv/rss_checker.sv @@
// ----------------------------------------------------------------------------
// rss_scoreboard
// scoreboard for the random sampling set: predicts and compares result beats
// ----------------------------------------------------------------------------
// Watches both stream channels. Every accepted request beat is run through a
// local copy of the set and the predicted result is queued. Every accepted
// result beat is compared, field by field, with the oldest queued prediction.
// ----------------------------------------------------------------------------
module rss_scoreboard
	import rss_pkg::*;
#(
	parameter int CAPACITY = 64
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	input  logic                 s_tready,
	input  logic [S_TDATA_W-1:0] s_tdata,   // [31:0] item_value, [62:32] random_word, [63] zero
	input  logic [KIND_W-1:0]    s_tuser,   // [1:0] req_type
	input  logic                 m_tvalid,
	input  logic                 m_tready,
	input  logic [M_TDATA_W-1:0] m_tdata,   // [31:0] picked_value, [38:32] member_count, [39] zero
	input  logic [KIND_W-1:0]    m_tuser,   // [1:0] status
	output int                   errors,
	output int                   pending,
	output int                   compared,
	output int                   full_refusals,
	output int                   empty_picks
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [KIND_W-1:0]   status;
		value_t              picked;
		logic [MCOUNT_W-1:0] count;
	} outcome_t;

	outcome_t    outcome_q[$];
	outcome_t    want;
	outcome_t    fresh;
	value_t      members[CAPACITY];
	int unsigned n_members;

	// applies one request to the local set and returns the result it causes
	function automatic outcome_t apply_request(logic [KIND_W-1:0] kind, value_t v,
			logic [RW_W-1:0] rw);
		outcome_t o;
		int       hit;
		o = '0;
		o.status = STAT_DONE;
		hit = -1;
		for (int i = 0; i < int'(n_members); i++)
			if (hit < 0 && members[i] == v)
				hit = i;
		case (kind)
			REQ_INSERT: begin
				if (hit >= 0)
					o.status = STAT_NOP;
				else if (n_members >= CAPACITY)
					o.status = STAT_FULL;
				else begin
					members[n_members] = v;
					n_members++;
				end
			end
			REQ_REMOVE: begin
				// last entry fills the freed slot
				if (hit < 0)
					o.status = STAT_NOP;
				else begin
					members[hit] = members[n_members - 1];
					n_members--;
				end
			end
			REQ_PICK: begin
				if (n_members == 0)
					o.status = STAT_EMPTY;
				else
					o.picked = members[rw % n_members];
			end
			default: ;
		endcase
		o.count = n_members[MCOUNT_W-1:0];
		return o;
	endfunction

	function automatic void check_field(string what, logic [VAL_W-1:0] exp_val,
			logic [VAL_W-1:0] act_val);
		if (act_val !== exp_val) begin
			errors++;
			$display("%0t ns: %s mismatch, expected %0h, got %0h", $time, what, exp_val, act_val);
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			outcome_q.delete();
			n_members     = 0;
			errors        = 0;
			pending       = 0;
			compared      = 0;
			full_refusals = 0;
			empty_picks   = 0;
		end else begin
			// result first: it always belongs to an earlier request
			if (m_tvalid && m_tready) begin
				if (outcome_q.size() == 0) begin
					errors++;
					$display("%0t ns: result beat with nothing outstanding, status %0d",
						$time, m_tuser);
				end else begin
					want = outcome_q.pop_front();
					compared++;
					check_field("status", VAL_W'(want.status), VAL_W'(m_tuser));
					check_field("picked_value", want.picked, m_tdata[31:0]);
					check_field("member_count", VAL_W'(want.count), VAL_W'(m_tdata[38:32]));
				end
			end
			if (s_tvalid && s_tready) begin
				fresh = apply_request(s_tuser, s_tdata[31:0], s_tdata[62:32]);
				outcome_q = {outcome_q, fresh};
				if (fresh.status == STAT_FULL)
					full_refusals++;
				if (fresh.status == STAT_EMPTY)
					empty_picks++;
			end
			pending = outcome_q.size();
		end
	end

endmodule

@@ tb/sv/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// stream-level testbench of the random sampling set
// ----------------------------------------------------------------------------
// A short directed run covers the empty set, the value extremes, duplicate
// inserts, absent removes, picks at the random-word extremes and the unused
// request code. Four paced phases follow: each fills the set past its
// capacity from a value pool, mixes random requests, drains it again and
// mixes once more. The checker beside the block predicts every result.
// ----------------------------------------------------------------------------
module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import rss_pkg::*;

	localparam int                CAPACITY   = 64;
	localparam int                POOL_N     = 96;    // more than fits, so fills hit full
	localparam logic [KIND_W-1:0] REQ_UNUSED = 2'd3;  // request code the block ignores

	logic                 clk;
	logic                 arst_n;
	logic                 s_tvalid;
	logic                 s_tready;
	logic [S_TDATA_W-1:0] s_tdata;    // [31:0] item_value, [62:32] random_word, [63] zero
	logic [KIND_W-1:0]    s_tuser;    // [1:0] req_type
	logic                 m_tvalid;
	logic                 m_tready;
	logic [M_TDATA_W-1:0] m_tdata;    // [31:0] picked_value, [38:32] member_count, [39] zero
	logic [KIND_W-1:0]    m_tuser;    // [1:0] status

	int errors;
	int pending;
	int compared;
	int full_refusals;
	int empty_picks;

	// pacing knobs, read at the falling edge by the drivers
	int idle_pct;
	int stall_pct;
	int hold_left;

	int     n_sent[4];
	value_t pool[POOL_N];

	random_sampling_set #(
		.CAPACITY(CAPACITY)
	) u_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser)
	);

	rss_scoreboard #(
		.CAPACITY(CAPACITY)
	) u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_tvalid     (s_tvalid),
		.s_tready     (s_tready),
		.s_tdata      (s_tdata),
		.s_tuser      (s_tuser),
		.m_tvalid     (m_tvalid),
		.m_tready     (m_tready),
		.m_tdata      (m_tdata),
		.m_tuser      (m_tuser),
		.errors       (errors),
		.pending      (pending),
		.compared     (compared),
		.full_refusals(full_refusals),
		.empty_picks  (empty_picks)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// result side: random stalls, or a long hold-off counted down here
	initial begin
		m_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_left > 0) begin
				m_tready <= 1'b0;
				hold_left--;
			end else
				m_tready <= ($urandom_range(99) >= stall_pct);
		end
	end

	// knobs change right after a rising edge so no driver sees them mid-step
	task automatic set_pace(int idle, int stall);
		@(posedge clk);
		idle_pct  = idle;
		stall_pct = stall;
		@(negedge clk);
	endtask

	// the last beat is withdrawn first so it is not offered twice
	task automatic start_hold(int cycles);
		s_tvalid <= 1'b0;
		@(posedge clk);
		hold_left = cycles;
		@(negedge clk);
	endtask

	// offers one request beat, entered and left at a falling edge
	task automatic send_req(logic [KIND_W-1:0] kind, value_t v, logic [RW_W-1:0] rw);
		while ($urandom_range(99) < idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= kind;
		s_tdata  <= {1'b0, rw, v};
		do @(posedge clk); while (!s_tready);
		@(negedge clk);
		n_sent[kind]++;
	endtask

	// sender holds still until every outstanding result has been checked
	task automatic wait_drained(int limit);
		s_tvalid <= 1'b0;
		@(negedge clk);
		for (int w = 0; w < limit && pending != 0; w++)
			@(negedge clk);
	endtask

	// one random request; mostly pool values so inserts and removes hit
	task automatic random_req(int insert_w, int remove_w);
		int                r;
		logic [KIND_W-1:0] kind;
		value_t            v;
		logic [RW_W-1:0]   rw;
		r = $urandom_range(99);
		if (r < insert_w)
			kind = REQ_INSERT;
		else if (r < insert_w + remove_w)
			kind = REQ_REMOVE;
		else if (r < 97)
			kind = REQ_PICK;
		else
			kind = REQ_UNUSED;
		v  = ($urandom_range(9) == 0) ? value_t'($urandom) : pool[$urandom_range(POOL_N - 1)];
		// small words make the remainder land on every slot, large ones toggle all bits
		rw = ($urandom_range(1) == 0) ? RW_W'($urandom_range(127)) : RW_W'($urandom);
		send_req(kind, v, rw);
	endtask

	// inserts the whole pool from a random start, running past capacity
	task automatic fill_set();
		int start;
		start = $urandom_range(POOL_N - 1);
		for (int i = 0; i < POOL_N; i++)
			send_req(REQ_INSERT, pool[(start + i) % POOL_N], RW_W'($urandom));
	endtask

	// removes the whole pool in a scrambled order, so hits land everywhere
	task automatic drain_set();
		int steps[5] = '{1, 5, 7, 11, 13};
		int start;
		int step;
		start = $urandom_range(POOL_N - 1);
		step  = steps[$urandom_range(4)];
		for (int i = 0; i < POOL_N; i++)
			send_req(REQ_REMOVE, pool[(start + i * step) % POOL_N], RW_W'($urandom));
	endtask

	initial begin
		int idle_by_phase[4]  = '{0, 55, 0, 26};
		int stall_by_phase[4] = '{0, 0, 55, 26};

		arst_n    = 1'b0;
		s_tvalid  = 1'b0;
		s_tdata   = '0;
		s_tuser   = REQ_INSERT;
		idle_pct  = 0;
		stall_pct = 0;
		hold_left = 0;
		foreach (n_sent[k])
			n_sent[k] = 0;

		// extremes first, the rest random
		pool[0] = value_t'(32'h8000_0000);
		pool[1] = value_t'(32'h7fff_ffff);
		pool[2] = value_t'(32'h0000_0000);
		pool[3] = value_t'(32'hffff_ffff);
		for (int i = 4; i < POOL_N; i++)
			pool[i] = value_t'($urandom);

		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: empty set corner cases
		send_req(REQ_PICK,   value_t'(0), RW_W'(0));
		send_req(REQ_REMOVE, value_t'(0), RW_W'(0));
		send_req(REQ_UNUSED, value_t'(32'hffff_ffff), RW_W'(31'h7fff_ffff));
		// value extremes go in, then a duplicate
		send_req(REQ_INSERT, value_t'(32'h8000_0000), RW_W'(0));
		send_req(REQ_INSERT, value_t'(32'h7fff_ffff), RW_W'(0));
		send_req(REQ_INSERT, value_t'(0), RW_W'(0));
		send_req(REQ_INSERT, value_t'(32'hffff_ffff), RW_W'(0));
		send_req(REQ_INSERT, value_t'(1), RW_W'(0));
		send_req(REQ_INSERT, value_t'(32'h7fff_ffff), RW_W'(0));
		// picks at the random-word extremes
		send_req(REQ_PICK, value_t'(32'hdead_beef), RW_W'(0));
		send_req(REQ_PICK, value_t'(0), RW_W'(31'h7fff_ffff));
		send_req(REQ_PICK, value_t'(0), RW_W'(4));
		// remove from the middle, an absent value, then the first slot
		send_req(REQ_REMOVE, value_t'(32'hffff_ffff), RW_W'(0));
		send_req(REQ_REMOVE, value_t'(12345), RW_W'(0));
		send_req(REQ_REMOVE, value_t'(32'h8000_0000), RW_W'(0));
		send_req(REQ_UNUSED, value_t'(32'h5555_aaaa), RW_W'(31'h2aaa_5555));
		send_req(REQ_PICK, value_t'(0), RW_W'(2));
		// empty it again, then hit the empty cases once more
		send_req(REQ_REMOVE, value_t'(1), RW_W'(0));
		send_req(REQ_REMOVE, value_t'(0), RW_W'(0));
		send_req(REQ_REMOVE, value_t'(32'h7fff_ffff), RW_W'(0));
		send_req(REQ_PICK, value_t'(0), RW_W'(31'h7fff_ffff));
		send_req(REQ_REMOVE, value_t'(32'h7fff_ffff), RW_W'(0));
		wait_drained(20000);

		for (int p = 0; p < 4; p++) begin
			set_pace(idle_by_phase[p], stall_by_phase[p]);
			fill_set();
			// long hold-off on the result side while requests keep coming
			if (p == 0)
				start_hold(400);
			for (int i = 0; i < 120; i++)
				random_req(35, 30);
			drain_set();
			for (int i = 0; i < 80; i++)
				random_req(55, 20);
			wait_drained(200000);
		end

		// let anything late show up before the verdict
		repeat (100) @(posedge clk);

		$display("covered %0d requests: %0d insert, %0d remove, %0d pick, %0d unused code",
			n_sent[0] + n_sent[1] + n_sent[2] + n_sent[3],
			n_sent[REQ_INSERT], n_sent[REQ_REMOVE], n_sent[REQ_PICK], n_sent[REQ_UNUSED]);
		$display("%0d results compared, %0d inserts refused as full, %0d picks from empty set",
			compared, full_refusals, empty_picks);
		if (pending != 0)
			$display("%0d expected results never arrived", pending);
		if (errors == 0 && pending == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

	// watchdog, far beyond the slowest legal run
	initial begin
		#4000000;
		$display("watchdog expired with %0d results outstanding", pending);
		$display("simulation failed");
		$finish;
	end

endmodule
